// File: src/tfr_pkg.sv
`timescale 1ns / 1ps

package tfr_pkg;

  // frame layout
  localparam int unsigned LONG_FRAME_BYTES  = 25;
  localparam int unsigned SHORT_FRAME_BYTES = 6;

  localparam logic [7:0] START_CODE     = 8'h50;
  localparam logic [7:0] TYPE_TELEMETRY = 8'h54;
  localparam logic [7:0] TYPE_MEASURE   = 8'h4D;
  localparam logic [7:0] TYPE_DEPTH     = 8'h53;
  localparam logic [7:0] SIGN_NEGATIVE  = 8'h01;

  // byte positions inside a long frame
  localparam logic [4:0] POS_START     = 5'd0;
  localparam logic [4:0] POS_TYPE      = 5'd1;
  localparam logic [4:0] POS_LON_SIGN  = 5'd4;
  localparam logic [4:0] POS_LON_LAST  = 5'd8;
  localparam logic [4:0] POS_LAT_SIGN  = 5'd9;
  localparam logic [4:0] POS_LAT_LAST  = 5'd13;
  localparam logic [4:0] POS_ALT_SIGN  = 5'd14;
  localparam logic [4:0] POS_ALT_LAST  = 5'd17;
  localparam logic [4:0] POS_SONAR_1ST = 5'd18;
  localparam logic [4:0] POS_SONAR_END = 5'd21;
  localparam logic [4:0] POS_CONF      = 5'd22;
  localparam logic [4:0] COUNT_MAX     = 5'd31;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_TELEMETRY_OK = 3'd0,
    ST_MEASURE_OK   = 3'd1,
    ST_DEPTH_OK     = 3'd2,
    ST_BAD_START    = 3'd3,
    ST_BAD_TYPE     = 3'd4,
    ST_BAD_LENGTH   = 3'd5,
    ST_BAD_CHECKSUM = 3'd6
  } frame_status_t;

  // classified frame, fields still in sign-magnitude form
  typedef struct packed {
    frame_status_t status;
    logic [32:0]   lon_sm;
    logic [32:0]   lat_sm;
    logic [24:0]   alt_sm;
    logic [31:0]   sonar;
    logic [7:0]    conf;
  } frame_rec_t;

  // result transaction
  typedef struct packed {
    logic               start_measurement;
    logic [7:0]         sonar_confidence;
    logic [31:0]        sonar_distance;
    logic signed [24:0] altitude;
    logic signed [32:0] latitude;
    logic signed [32:0] longitude;
    frame_status_t      frame_status;
  } result_t;

  localparam int unsigned RESULT_BITS = $bits(result_t);
  localparam int unsigned OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

// File: src/tfr_front.sv
`timescale 1ns / 1ps

module tfr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_ok,
  input  logic [7:0]         data_byte,
  input  logic               burst_end,
  output logic               rec_push,
  output tfr_pkg::frame_rec_t rec
);

  logic [4:0]  byte_count_r, byte_count_nxt;
  logic [15:0] run_sum_r, run_sum_nxt;
  logic [15:0] prev_sum_r, prev_sum_nxt;
  logic        start_ok_r, start_ok_nxt;
  logic [7:0]  frame_type_r, frame_type_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic [32:0] lon_r, lon_nxt;
  logic [32:0] lat_r, lat_nxt;
  logic [24:0] alt_r, alt_nxt;
  logic [31:0] sonar_r, sonar_nxt;
  logic [7:0]  conf_r, conf_nxt;

  logic [4:0]  idx;
  logic [5:0]  len;
  logic        is_long;
  logic        is_short;
  logic        neg_byte;
  tfr_pkg::frame_status_t status;

  assign idx      = byte_count_r;
  assign neg_byte = (data_byte == tfr_pkg::SIGN_NEGATIVE);

  // field capture for the current byte
  always_comb begin
    start_ok_nxt   = start_ok_r;
    frame_type_nxt = frame_type_r;
    lon_nxt        = lon_r;
    lat_nxt        = lat_r;
    alt_nxt        = alt_r;
    sonar_nxt      = sonar_r;
    conf_nxt       = conf_r;
    if (idx == tfr_pkg::POS_START) begin
      start_ok_nxt = (data_byte == tfr_pkg::START_CODE);
    end
    if (idx == tfr_pkg::POS_TYPE) begin
      frame_type_nxt = data_byte;
    end
    if (idx == tfr_pkg::POS_LON_SIGN) begin
      lon_nxt[32] = neg_byte;
    end else if (idx > tfr_pkg::POS_LON_SIGN && idx <= tfr_pkg::POS_LON_LAST) begin
      lon_nxt[31:0] = {lon_r[23:0], data_byte};
    end
    if (idx == tfr_pkg::POS_LAT_SIGN) begin
      lat_nxt[32] = neg_byte;
    end else if (idx > tfr_pkg::POS_LAT_SIGN && idx <= tfr_pkg::POS_LAT_LAST) begin
      lat_nxt[31:0] = {lat_r[23:0], data_byte};
    end
    if (idx == tfr_pkg::POS_ALT_SIGN) begin
      alt_nxt[24] = neg_byte;
    end else if (idx > tfr_pkg::POS_ALT_SIGN && idx <= tfr_pkg::POS_ALT_LAST) begin
      alt_nxt[23:0] = {alt_r[15:0], data_byte};
    end
    if (idx >= tfr_pkg::POS_SONAR_1ST && idx <= tfr_pkg::POS_SONAR_END) begin
      sonar_nxt = {sonar_r[23:0], data_byte};
    end
    if (idx == tfr_pkg::POS_CONF) begin
      conf_nxt = data_byte;
    end
  end

  // running checksum and the two newest bytes
  assign tail_nxt     = {tail_r[7:0], data_byte};
  assign prev_sum_nxt = run_sum_r;
  assign run_sum_nxt  = run_sum_r + {8'd0, data_byte};
  assign byte_count_nxt = (byte_count_r == tfr_pkg::COUNT_MAX) ? byte_count_r
                                                               : byte_count_r + 5'd1;

  // classification at the burst end, checks in priority order
  assign len      = {1'b0, idx} + 6'd1;
  assign is_long  = (frame_type_nxt == tfr_pkg::TYPE_TELEMETRY) ||
                    (frame_type_nxt == tfr_pkg::TYPE_MEASURE);
  assign is_short = (frame_type_nxt == tfr_pkg::TYPE_DEPTH);

  always_comb begin
    if (!start_ok_nxt) begin
      status = tfr_pkg::ST_BAD_START;
    end else if (len < 6'd2 || (!is_long && !is_short)) begin
      status = tfr_pkg::ST_BAD_TYPE;
    end else if (is_long && len != 6'(tfr_pkg::LONG_FRAME_BYTES)) begin
      status = tfr_pkg::ST_BAD_LENGTH;
    end else if (is_short && len != 6'(tfr_pkg::SHORT_FRAME_BYTES)) begin
      status = tfr_pkg::ST_BAD_LENGTH;
    end else if (prev_sum_r != tail_nxt) begin
      status = tfr_pkg::ST_BAD_CHECKSUM;
    end else if (is_short) begin
      status = tfr_pkg::ST_DEPTH_OK;
    end else if (frame_type_nxt == tfr_pkg::TYPE_MEASURE) begin
      status = tfr_pkg::ST_MEASURE_OK;
    end else begin
      status = tfr_pkg::ST_TELEMETRY_OK;
    end
  end

  assign rec_push    = byte_ok && burst_end;
  assign rec.status  = status;
  assign rec.lon_sm  = lon_nxt;
  assign rec.lat_sm  = lat_nxt;
  assign rec.alt_sm  = alt_nxt;
  assign rec.sonar   = sonar_nxt;
  assign rec.conf    = conf_nxt;

  // burst state, cleared after every burst end
  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      byte_count_r <= '0;
      run_sum_r    <= '0;
      prev_sum_r   <= '0;
      start_ok_r   <= 1'b0;
      frame_type_r <= '0;
      tail_r       <= '0;
      lon_r        <= '0;
      lat_r        <= '0;
      alt_r        <= '0;
      sonar_r      <= '0;
      conf_r       <= '0;
    end else if (byte_ok) begin
      byte_count_r <= byte_count_nxt;
      run_sum_r    <= run_sum_nxt;
      prev_sum_r   <= prev_sum_nxt;
      start_ok_r   <= start_ok_nxt;
      frame_type_r <= frame_type_nxt;
      tail_r       <= tail_nxt;
      lon_r        <= lon_nxt;
      lat_r        <= lat_nxt;
      alt_r        <= alt_nxt;
      sonar_r      <= sonar_nxt;
      conf_r       <= conf_nxt;
    end
  end

endmodule

// File: src/tfr_queue.sv
`timescale 1ns / 1ps

module tfr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tfr_pkg::frame_rec_t push_data,
  output logic                full,
  input  logic                pop,
  output tfr_pkg::frame_rec_t pop_data,
  output logic                empty
);

  localparam int unsigned DEPTH  = tfr_pkg::QUEUE_DEPTH;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  tfr_pkg::frame_rec_t mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r;
  logic [IDX_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + IDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/tfr_back.sv
`timescale 1ns / 1ps

module tfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rec_avail,
  input  tfr_pkg::frame_rec_t rec,
  output logic                rec_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output tfr_pkg::result_t    res
);

  logic             out_valid_r;
  tfr_pkg::result_t out_r;
  tfr_pkg::result_t out_nxt;
  logic             data_ok;

  assign rec_pop = rec_avail && (!out_valid_r || res_ready);
  assign data_ok = (rec.status == tfr_pkg::ST_TELEMETRY_OK) ||
                   (rec.status == tfr_pkg::ST_MEASURE_OK);

  // sign-magnitude to two's complement, fields only for good data frames
  always_comb begin
    out_nxt              = '0;
    out_nxt.frame_status = rec.status;
    if (data_ok) begin
      out_nxt.longitude = rec.lon_sm[32] ? -$signed({1'b0, rec.lon_sm[31:0]})
                                         :  $signed({1'b0, rec.lon_sm[31:0]});
      out_nxt.latitude  = rec.lat_sm[32] ? -$signed({1'b0, rec.lat_sm[31:0]})
                                         :  $signed({1'b0, rec.lat_sm[31:0]});
      out_nxt.altitude  = rec.alt_sm[24] ? -$signed({1'b0, rec.alt_sm[23:0]})
                                         :  $signed({1'b0, rec.alt_sm[23:0]});
      out_nxt.sonar_distance    = rec.sonar;
      out_nxt.sonar_confidence  = rec.conf;
      out_nxt.start_measurement = (rec.status == tfr_pkg::ST_MEASURE_OK);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_pop) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      out_r <= out_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

// File: src/telemetry_frame_receiver.sv
`timescale 1ns / 1ps

// Telemetry frame receiver. Takes one received serial byte per transaction on
// the in_ stream, with in_tlast on the last byte of each burst, and gives one
// result transaction per burst: the frame status (0 telemetry ok, 1 measure ok,
// 2 depth request ok, 3 bad start, 4 unknown type, 5 bad length, 6 bad checksum)
// and, for telemetry and measure frames, the decoded position, sonar reading and
// start flag. One byte is taken every cycle while in_tready is high; the front
// keeps a running checksum and field accumulators, so it never stalls a byte. A
// result passes through the queue and is then loaded into the output register,
// which raises out_tvalid, once that register is empty or its result is taken. A
// two-entry queue between the classifier and the output stage keeps bytes flowing
// while a result waits on out_tready; in_tready drops only when that queue is full.

module telemetry_frame_receiver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // data_byte
  input  logic                                 in_tlast,   // burst_end
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // frame_status[2:0], longitude[35:3], latitude[68:36], altitude[93:69],
  // sonar_distance[125:94], sonar_confidence[133:126], start_measurement[134]
  output logic [tfr_pkg::OUT_TDATA_BITS-1:0]   out_tdata
);

  logic                in_ok;
  logic                rec_push;
  logic                q_full;
  logic                q_empty;
  logic                rec_pop;
  tfr_pkg::frame_rec_t front_rec;
  tfr_pkg::frame_rec_t back_rec;
  tfr_pkg::result_t    res;

  assign in_tready = !q_full;
  assign in_ok     = in_tvalid && in_tready;

  tfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_ok   (in_ok),
    .data_byte (in_tdata),
    .burst_end (in_tlast),
    .rec_push  (rec_push),
    .rec       (front_rec)
  );

  tfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (front_rec),
    .full      (q_full),
    .pop       (rec_pop),
    .pop_data  (back_rec),
    .empty     (q_empty)
  );

  tfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_avail (!q_empty),
    .rec       (back_rec),
    .rec_pop   (rec_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pad the result up to whole bytes
  assign out_tdata = {{(tfr_pkg::OUT_TDATA_BITS - tfr_pkg::RESULT_BITS){1'b0}}, res};

endmodule
